// File: sv/rssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rssc_pkg;

	localparam int DIST_W  = 16;
	localparam int BOUND_W = 12;
	localparam int CLASS_W = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [BOUND_W-1:0] bound_t;
	typedef logic [CLASS_W-1:0] class_t;

	localparam class_t CLASS_NONE      = 3'd0;
	localparam class_t CLASS_TOO_CLOSE = 3'd1;
	localparam class_t CLASS_RIGHT     = 3'd2;
	localparam class_t CLASS_LEFT      = 3'd3;
	localparam class_t CLASS_MIDDLE    = 3'd4;

	localparam dist_t DIST_MAX = '1;

	// register word indexes (byte address / 4)
	localparam logic [1:0] REG_RIGHT_END  = 2'd0;
	localparam logic [1:0] REG_LEFT_START = 2'd1;
	localparam logic [1:0] REG_FRONT_THR  = 2'd2;
	localparam logic [1:0] REG_BACKUP_THR = 2'd3;

	localparam bound_t RST_RIGHT_END  = 12'd120;
	localparam bound_t RST_LEFT_START = 12'd240;
	localparam dist_t  RST_FRONT_THR  = 16'd1200;
	localparam dist_t  RST_BACKUP_THR = 16'd500;

endpackage

`default_nettype wire

// File: sv/range_scan_sector_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a sample is captured in the input register, then folded into the sector
//   minima the next cycle; a last sample's result goes from the input register to the result register and on to res_*.
// Throughput: one sample per cycle while req_stall is low; req_stall rises only when a last sample waits on a
//   result register that is still full and stalled.
// Reset (arst_n low, async): scan state empty, previous class none, registers at defaults.
module range_scan_sector_classifier_core #(
	parameter int MAX_SAMPLES = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// APB-style configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [rssc_pkg::ADDR_W-1:0]  paddr,
	input  wire  [rssc_pkg::DATA_W-1:0]  pwdata,
	output logic [rssc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// sample request channel
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire  [15:0]                  range_mm,
	input  wire                          last_sample,
	// result channel
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic [2:0]                   sensor_state,
	output logic [15:0]                  left_minimum,
	output logic [15:0]                  middle_minimum,
	output logic [15:0]                  right_minimum
);

	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CMP_W = (IDX_W > rssc_pkg::BOUND_W) ? IDX_W : rssc_pkg::BOUND_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

	// ---------------- configuration registers ----------------
	rssc_pkg::bound_t right_end_q, left_start_q;
	rssc_pkg::dist_t  front_thr_q, backup_thr_q;
	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_end_q  <= rssc_pkg::RST_RIGHT_END;
			left_start_q <= rssc_pkg::RST_LEFT_START;
			front_thr_q  <= rssc_pkg::RST_FRONT_THR;
			backup_thr_q <= rssc_pkg::RST_BACKUP_THR;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rssc_pkg::REG_RIGHT_END:  right_end_q  <= pwdata[rssc_pkg::BOUND_W-1:0];
				rssc_pkg::REG_LEFT_START: left_start_q <= pwdata[rssc_pkg::BOUND_W-1:0];
				rssc_pkg::REG_FRONT_THR:  front_thr_q  <= pwdata[rssc_pkg::DIST_W-1:0];
				rssc_pkg::REG_BACKUP_THR: backup_thr_q <= pwdata[rssc_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			rssc_pkg::REG_RIGHT_END:
				prdata = {{(rssc_pkg::DATA_W-rssc_pkg::BOUND_W){1'b0}}, right_end_q};
			rssc_pkg::REG_LEFT_START:
				prdata = {{(rssc_pkg::DATA_W-rssc_pkg::BOUND_W){1'b0}}, left_start_q};
			rssc_pkg::REG_FRONT_THR:
				prdata = {{(rssc_pkg::DATA_W-rssc_pkg::DIST_W){1'b0}}, front_thr_q};
			rssc_pkg::REG_BACKUP_THR:
				prdata = {{(rssc_pkg::DATA_W-rssc_pkg::DIST_W){1'b0}}, backup_thr_q};
			default: prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic             valid_s1, last_s1;
	rssc_pkg::dist_t  range_s1;
	logic             advance_s1;   // s1 content is consumed this cycle
	logic             req_take;

	// Only a last sample needs the result register; others always drain.
	assign advance_s1 = valid_s1 && (!last_s1 || !res_valid || !res_stall);
	assign req_stall  = valid_s1 && !advance_s1;
	assign req_take   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			range_s1 <= range_mm;
			last_s1  <= last_sample;
		end
	end

	// ---------------- scan state ----------------
	logic [IDX_W-1:0]  idx_q;
	rssc_pkg::dist_t   left_q, middle_q, right_q;
	logic              obstructed_q;
	rssc_pkg::class_t  prev_class_q;

	logic [CMP_W-1:0]  idx_ext, left_start_ext, right_end_ext;
	logic              in_left, in_middle, in_right;
	rssc_pkg::dist_t   left_n, middle_n, right_n;
	logic              obstructed_n;
	rssc_pkg::class_t  class_n;
	logic              too_close;

	assign idx_ext        = CMP_W'(idx_q);
	assign left_start_ext = CMP_W'(left_start_q);
	assign right_end_ext  = CMP_W'(right_end_q);

	assign in_left   = idx_ext >= left_start_ext;
	assign in_middle = !in_left && (idx_ext > right_end_ext);
	assign in_right  = !in_left && !in_middle;

	// sector minima including the sample in s1
	assign left_n   = (in_left   && range_s1 < left_q)   ? range_s1 : left_q;
	assign middle_n = (in_middle && range_s1 < middle_q) ? range_s1 : middle_q;
	assign right_n  = (in_right  && range_s1 < right_q)  ? range_s1 : right_q;
	assign obstructed_n = obstructed_q || (range_s1 < front_thr_q);

	assign too_close = (left_n <= backup_thr_q) || (right_n <= backup_thr_q)
		|| (middle_n <= backup_thr_q);

	always_comb begin
		if (!obstructed_n) begin
			class_n = rssc_pkg::CLASS_NONE;
		end else if (too_close) begin
			class_n = rssc_pkg::CLASS_TOO_CLOSE;
		end else if (left_n > right_n && middle_n > right_n) begin
			class_n = rssc_pkg::CLASS_RIGHT;
		end else if (right_n > left_n && middle_n > left_n) begin
			class_n = rssc_pkg::CLASS_LEFT;
		end else if (right_n > middle_n && left_n > middle_n) begin
			class_n = rssc_pkg::CLASS_MIDDLE;
		end else begin
			class_n = prev_class_q;   // tie under obstruction keeps the old class
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			left_q       <= rssc_pkg::DIST_MAX;
			middle_q     <= rssc_pkg::DIST_MAX;
			right_q      <= rssc_pkg::DIST_MAX;
			obstructed_q <= 1'b0;
			prev_class_q <= rssc_pkg::CLASS_NONE;
		end else if (advance_s1) begin
			if (last_s1) begin
				idx_q        <= '0;
				left_q       <= rssc_pkg::DIST_MAX;
				middle_q     <= rssc_pkg::DIST_MAX;
				right_q      <= rssc_pkg::DIST_MAX;
				obstructed_q <= 1'b0;
				prev_class_q <= class_n;
			end else begin
				// index saturates on an overlong scan
				if (idx_q != IDX_LAST) begin
					idx_q <= idx_q + 1'b1;
				end
				left_q       <= left_n;
				middle_q     <= middle_n;
				right_q      <= right_n;
				obstructed_q <= obstructed_n;
			end
		end
	end

	// ---------------- result register ----------------
	logic load_res;
	assign load_res = advance_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_res) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			sensor_state   <= class_n;
			left_minimum   <= left_n;
			middle_minimum <= middle_n;
			right_minimum  <= right_n;
		end
	end

`ifndef NO_ASSERTIONS
	// a finished scan leaves the scan state empty
	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (idx_q == '0) && !obstructed_q && (left_q == rssc_pkg::DIST_MAX))
		else $error("scan state not cleared after last sample");

	// held request only while something sits in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && last_s1 && res_valid && res_stall)
		else $error("request stalled without a blocked result");

	// emitted class is one of the defined codes
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> sensor_state <= rssc_pkg::CLASS_MIDDLE)
		else $error("undefined sensor state emitted");

	// a result is never overwritten while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(sensor_state)
			&& $stable(right_minimum))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
